### hdl/wmb_pkg.sv
// Package for the wavelet matrix builder: sizes, controller states,
// datapath command codes and small helper functions. No dependencies.
package wmb_pkg;

  localparam int MAX_LEN    = 4096;
  localparam int POS_W      = 12;
  localparam int LEN_W      = 13;
  localparam int MAX_HEIGHT = 8;
  localparam int LVL_W      = 3;
  localparam int HGT_W      = 4;
  localparam int SYM_W      = 8;
  localparam int BKT_W      = 7;          // prefixes of levels 1..7
  localparam int NUM_BKT    = 1 << BKT_W;
  localparam int BA_W       = LVL_W + POS_W;

  typedef enum logic [3:0] {
    ST_IDLE, ST_QWAIT,
    ST_L0_RD, ST_L0_WR,
    ST_CLR,
    ST_CNT_RD, ST_CNT_HR, ST_CNT_WR,
    ST_BRD_RD, ST_BRD_WR,
    ST_PL_RD, ST_PL_BR, ST_PL_WR
  } state_t;

  typedef enum logic [4:0] {
    OP_NOP, OP_LOAD, OP_QUERY, OP_QOUT,
    OP_TXT_RD, OP_L0_WR, OP_L0_END,
    OP_CLR, OP_CNT_HR, OP_CNT_WR, OP_CNT_END,
    OP_BRD_RD, OP_BRD_WR, OP_BRD_END,
    OP_PL_BR, OP_PL_WR, OP_PL_END
  } op_t;

  typedef struct packed {
    logic i_done;      // text index reached length
    logic clr_last;    // last bucket of the clear sweep
    logic r_done;      // bucket index reached bucket count
    logic last_level;  // current level is the bottom one
    logic out_free;    // output register can take a word
  } dp_status_t;

  localparam int REQ_LOAD  = 0;
  localparam int REQ_QUERY = 1;

  function automatic logic [HGT_W-1:0] clamp_height(input logic [HGT_W-1:0] v);
    logic [HGT_W-1:0] r;
    r = v;
    if (v < HGT_W'(2)) r = HGT_W'(2);
    else if (v > HGT_W'(MAX_HEIGHT)) r = HGT_W'(MAX_HEIGHT);
    return r;
  endfunction

  // reverse the low nbits bits of v
  function automatic logic [BKT_W-1:0] rev_bits(input logic [BKT_W-1:0] v,
                                                input logic [LVL_W-1:0] nbits);
    logic [BKT_W-1:0] r;
    r = '0;
    for (int k = 0; k < BKT_W; k++) begin
      if (k < int'(nbits)) r[int'(nbits) - 1 - k] = v[k];
    end
    return r;
  endfunction

endpackage

### hdl/wmb_if.sv
// Channel interfaces of the wavelet matrix builder: input, result and
// height configuration. Depends on wmb_pkg.
interface wmb_in_if;
  logic                        valid;
  logic                        ready;
  logic                        req_type;
  logic [wmb_pkg::SYM_W-1:0]   symbol;
  logic                        last_symbol;
  logic [wmb_pkg::LVL_W-1:0]   level;
  logic [wmb_pkg::POS_W-1:0]   position;
  modport source (output valid, req_type, symbol, last_symbol, level, position,
                  input ready);
  modport sink   (input valid, req_type, symbol, last_symbol, level, position,
                  output ready);
endinterface

interface wmb_out_if;
  logic                        valid;
  logic                        ready;
  logic                        bit_value;
  logic [wmb_pkg::LEN_W-1:0]   zero_count;
  logic                        out_of_range;
  modport source (output valid, bit_value, zero_count, out_of_range, input ready);
  modport sink   (input valid, bit_value, zero_count, out_of_range, output ready);
endinterface

interface wmb_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [wmb_pkg::HGT_W-1:0]   height;
  modport source (output valid, height, input ready);
  modport sink   (input valid, height, output ready);
endinterface

### hdl/wmb_ctrl.sv
// Controller of the wavelet matrix builder: sequences loads, queries and
// the level-by-level build. Depends on wmb_pkg.
module wmb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_req_type,
  input  logic                in_last_symbol,
  input  wmb_pkg::dp_status_t status,
  output logic                in_ready,
  output wmb_pkg::op_t        op
);

  wmb_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= wmb_pkg::ST_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      wmb_pkg::ST_IDLE: begin
        if (in_valid) begin
          if (in_req_type == 1'(wmb_pkg::REQ_QUERY)) state_nxt = wmb_pkg::ST_QWAIT;
          else if (in_last_symbol) state_nxt = wmb_pkg::ST_L0_RD;
        end
      end
      wmb_pkg::ST_QWAIT:  if (status.out_free) state_nxt = wmb_pkg::ST_IDLE;
      wmb_pkg::ST_L0_RD:  state_nxt = status.i_done ? wmb_pkg::ST_CLR : wmb_pkg::ST_L0_WR;
      wmb_pkg::ST_L0_WR:  state_nxt = wmb_pkg::ST_L0_RD;
      wmb_pkg::ST_CLR:    if (status.clr_last) state_nxt = wmb_pkg::ST_CNT_RD;
      wmb_pkg::ST_CNT_RD: state_nxt = status.i_done ? wmb_pkg::ST_BRD_RD : wmb_pkg::ST_CNT_HR;
      wmb_pkg::ST_CNT_HR: state_nxt = wmb_pkg::ST_CNT_WR;
      wmb_pkg::ST_CNT_WR: state_nxt = wmb_pkg::ST_CNT_RD;
      wmb_pkg::ST_BRD_RD: state_nxt = status.r_done ? wmb_pkg::ST_PL_RD : wmb_pkg::ST_BRD_WR;
      wmb_pkg::ST_BRD_WR: state_nxt = wmb_pkg::ST_BRD_RD;
      wmb_pkg::ST_PL_RD: begin
        if (!status.i_done) state_nxt = wmb_pkg::ST_PL_BR;
        else if (status.last_level) state_nxt = wmb_pkg::ST_IDLE;
        else state_nxt = wmb_pkg::ST_CLR;
      end
      wmb_pkg::ST_PL_BR:  state_nxt = wmb_pkg::ST_PL_WR;
      wmb_pkg::ST_PL_WR:  state_nxt = wmb_pkg::ST_PL_RD;
      default:            state_nxt = wmb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    op       = wmb_pkg::OP_NOP;
    unique case (state_r)
      wmb_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid)
          op = (in_req_type == 1'(wmb_pkg::REQ_QUERY)) ? wmb_pkg::OP_QUERY
                                                        : wmb_pkg::OP_LOAD;
      end
      wmb_pkg::ST_QWAIT:  op = wmb_pkg::OP_QOUT;
      wmb_pkg::ST_L0_RD:  op = status.i_done ? wmb_pkg::OP_L0_END : wmb_pkg::OP_TXT_RD;
      wmb_pkg::ST_L0_WR:  op = wmb_pkg::OP_L0_WR;
      wmb_pkg::ST_CLR:    op = wmb_pkg::OP_CLR;
      wmb_pkg::ST_CNT_RD: op = status.i_done ? wmb_pkg::OP_CNT_END : wmb_pkg::OP_TXT_RD;
      wmb_pkg::ST_CNT_HR: op = wmb_pkg::OP_CNT_HR;
      wmb_pkg::ST_CNT_WR: op = wmb_pkg::OP_CNT_WR;
      wmb_pkg::ST_BRD_RD: op = status.r_done ? wmb_pkg::OP_BRD_END : wmb_pkg::OP_BRD_RD;
      wmb_pkg::ST_BRD_WR: op = wmb_pkg::OP_BRD_WR;
      wmb_pkg::ST_PL_RD:  op = status.i_done ? wmb_pkg::OP_PL_END : wmb_pkg::OP_TXT_RD;
      wmb_pkg::ST_PL_BR:  op = wmb_pkg::OP_PL_BR;
      wmb_pkg::ST_PL_WR:  op = wmb_pkg::OP_PL_WR;
      default:            op = wmb_pkg::OP_NOP;
    endcase
  end

endmodule

### hdl/wmb_dp.sv
// Datapath of the wavelet matrix builder: text, level bit, histogram and
// border memories, counters, height register and result register.
// Depends on wmb_pkg.
module wmb_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  wmb_pkg::op_t                  op,
  output wmb_pkg::dp_status_t           status,
  input  logic [wmb_pkg::SYM_W-1:0]     in_symbol,
  input  logic                          in_last_symbol,
  input  logic [wmb_pkg::LVL_W-1:0]     in_level,
  input  logic [wmb_pkg::POS_W-1:0]     in_position,
  input  logic                          cfg_we,
  input  logic [wmb_pkg::HGT_W-1:0]     cfg_height,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_bit_value,
  output logic [wmb_pkg::LEN_W-1:0]     out_zero_count,
  output logic                          out_out_of_range
);

  logic [wmb_pkg::SYM_W-1:0] text_mem [wmb_pkg::MAX_LEN];
  logic                      bits_mem [wmb_pkg::MAX_LEN * wmb_pkg::MAX_HEIGHT];
  logic [wmb_pkg::LEN_W-1:0] hist_mem [wmb_pkg::NUM_BKT];
  logic [wmb_pkg::LEN_W-1:0] brd_mem  [wmb_pkg::NUM_BKT];
  logic [wmb_pkg::LEN_W-1:0] zeros_r  [wmb_pkg::MAX_HEIGHT];

  logic [wmb_pkg::HGT_W-1:0] height_r, bh_r;
  logic [wmb_pkg::LEN_W-1:0] len_r, i_r, zacc_r, run_r;
  logic [wmb_pkg::BKT_W:0]   r_r;
  logic [wmb_pkg::LVL_W-1:0] l_r;
  logic                      built_r;
  logic [wmb_pkg::SYM_W-1:0] txt_rd_r;
  logic [wmb_pkg::LEN_W-1:0] hist_rd_r, brd_rd_r;
  logic [wmb_pkg::BKT_W-1:0] p_r;
  logic                      bit_r, qbit_rd_r, q_oor_r;
  logic [wmb_pkg::LEN_W-1:0] q_zc_r;
  logic                      out_valid_r, out_bit_r, out_oor_r;
  logic [wmb_pkg::LEN_W-1:0] out_zc_r;

  logic [wmb_pkg::SYM_W:0]   mask_w;
  logic [wmb_pkg::SYM_W-1:0] c;
  logic [wmb_pkg::HGT_W-1:0] sh_pre, sh_bit;
  logic [wmb_pkg::BKT_W-1:0] p, prev;
  logic                      cbit;
  logic [wmb_pkg::BKT_W:0]   nb;
  logic                      q_oor, out_free;

  // masked symbol, its prefix above the level and its bit at the level
  always_comb begin
    mask_w = ((wmb_pkg::SYM_W+1)'(1) << bh_r) - (wmb_pkg::SYM_W+1)'(1);
    c      = txt_rd_r & mask_w[wmb_pkg::SYM_W-1:0];
    sh_pre = bh_r - wmb_pkg::HGT_W'(l_r);
    sh_bit = sh_pre - wmb_pkg::HGT_W'(1);
    p      = wmb_pkg::BKT_W'(c >> sh_pre);
    cbit   = c[sh_bit[wmb_pkg::LVL_W-1:0]];
    prev   = wmb_pkg::rev_bits(r_r[wmb_pkg::BKT_W-1:0], l_r);
    nb     = (wmb_pkg::BKT_W+1)'(1) << l_r;
  end

  assign out_free = !out_valid_r || out_ready;
  assign q_oor = !built_r || (wmb_pkg::HGT_W'(in_level) >= bh_r)
              || (wmb_pkg::LEN_W'(in_position) >= len_r);

  assign status.i_done     = (i_r == len_r);
  assign status.clr_last   = (r_r == nb - (wmb_pkg::BKT_W+1)'(1));
  assign status.r_done     = (r_r == nb);
  assign status.last_level = (wmb_pkg::HGT_W'(l_r) == bh_r - wmb_pkg::HGT_W'(1));
  assign status.out_free   = out_free;

  // memories
  always_ff @(posedge clk) begin
    if (op == wmb_pkg::OP_LOAD) begin
      if (built_r)
        text_mem[0] <= in_symbol;
      else if (len_r < wmb_pkg::LEN_W'(wmb_pkg::MAX_LEN))
        text_mem[len_r[wmb_pkg::POS_W-1:0]] <= in_symbol;
    end
    if (op == wmb_pkg::OP_TXT_RD) txt_rd_r <= text_mem[i_r[wmb_pkg::POS_W-1:0]];

    if (op == wmb_pkg::OP_L0_WR)
      bits_mem[{wmb_pkg::LVL_W'(0), i_r[wmb_pkg::POS_W-1:0]}] <= cbit;
    else if (op == wmb_pkg::OP_PL_WR && brd_rd_r < wmb_pkg::LEN_W'(wmb_pkg::MAX_LEN))
      bits_mem[{l_r, brd_rd_r[wmb_pkg::POS_W-1:0]}] <= bit_r;
    if (op == wmb_pkg::OP_QUERY) qbit_rd_r <= bits_mem[{in_level, in_position}];

    if (op == wmb_pkg::OP_CLR)
      hist_mem[r_r[wmb_pkg::BKT_W-1:0]] <= '0;
    else if (op == wmb_pkg::OP_CNT_WR)
      hist_mem[p_r] <= hist_rd_r + wmb_pkg::LEN_W'(1);
    if (op == wmb_pkg::OP_CNT_HR)      hist_rd_r <= hist_mem[p];
    else if (op == wmb_pkg::OP_BRD_RD) hist_rd_r <= hist_mem[prev];

    if (op == wmb_pkg::OP_BRD_WR)     brd_mem[p_r] <= run_r;
    else if (op == wmb_pkg::OP_PL_WR) brd_mem[p_r] <= brd_rd_r + wmb_pkg::LEN_W'(1);
    if (op == wmb_pkg::OP_PL_BR)      brd_rd_r <= brd_mem[p];
  end

  // payload registers
  always_ff @(posedge clk) begin
    unique case (op)
      wmb_pkg::OP_CNT_HR: p_r <= p;
      wmb_pkg::OP_BRD_RD: p_r <= prev;
      wmb_pkg::OP_PL_BR: begin
        p_r   <= p;
        bit_r <= cbit;
      end
      wmb_pkg::OP_QUERY: begin
        q_oor_r <= q_oor;
        q_zc_r  <= q_oor ? '0 : zeros_r[in_level];
      end
      wmb_pkg::OP_QOUT: begin
        if (out_free) begin
          out_bit_r <= q_oor_r ? 1'b0 : qbit_rd_r;
          out_zc_r  <= q_zc_r;
          out_oor_r <= q_oor_r;
        end
      end
      default: ;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r    <= wmb_pkg::HGT_W'(wmb_pkg::MAX_HEIGHT);
      bh_r        <= '0;
      len_r       <= '0;
      built_r     <= 1'b0;
      i_r         <= '0;
      r_r         <= '0;
      l_r         <= '0;
      zacc_r      <= '0;
      run_r       <= '0;
      out_valid_r <= 1'b0;
      for (int k = 0; k < wmb_pkg::MAX_HEIGHT; k++) zeros_r[k] <= '0;
    end else begin
      if (cfg_we) height_r <= wmb_pkg::clamp_height(cfg_height);
      // a new word replaces one that leaves in the same cycle
      if (op == wmb_pkg::OP_QOUT && out_free) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready)     out_valid_r <= 1'b0;
      unique case (op)
        wmb_pkg::OP_LOAD: begin
          built_r <= 1'b0;
          if (built_r) len_r <= wmb_pkg::LEN_W'(1);
          else if (len_r < wmb_pkg::LEN_W'(wmb_pkg::MAX_LEN))
            len_r <= len_r + wmb_pkg::LEN_W'(1);
          if (in_last_symbol) begin
            bh_r   <= height_r;
            i_r    <= '0;
            l_r    <= '0;
            zacc_r <= '0;
          end
        end
        wmb_pkg::OP_L0_WR: begin
          i_r <= i_r + wmb_pkg::LEN_W'(1);
          if (!cbit) zacc_r <= zacc_r + wmb_pkg::LEN_W'(1);
        end
        wmb_pkg::OP_L0_END: begin
          zeros_r[0] <= zacc_r;
          l_r        <= wmb_pkg::LVL_W'(1);
          r_r        <= '0;
        end
        wmb_pkg::OP_CLR: begin
          i_r <= '0;
          r_r <= status.clr_last ? '0 : r_r + (wmb_pkg::BKT_W+1)'(1);
        end
        wmb_pkg::OP_CNT_WR: i_r <= i_r + wmb_pkg::LEN_W'(1);
        wmb_pkg::OP_CNT_END: begin
          r_r   <= '0;
          run_r <= '0;
        end
        wmb_pkg::OP_BRD_WR: begin
          run_r <= run_r + hist_rd_r;
          r_r   <= r_r + (wmb_pkg::BKT_W+1)'(1);
        end
        wmb_pkg::OP_BRD_END: begin
          i_r    <= '0;
          zacc_r <= '0;
        end
        wmb_pkg::OP_PL_WR: begin
          i_r <= i_r + wmb_pkg::LEN_W'(1);
          if (!bit_r) zacc_r <= zacc_r + wmb_pkg::LEN_W'(1);
        end
        wmb_pkg::OP_PL_END: begin
          zeros_r[l_r] <= zacc_r;
          r_r          <= '0;
          if (status.last_level) built_r <= 1'b1;
          else l_r <= l_r + wmb_pkg::LVL_W'(1);
        end
        default: ;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_bit_value    = out_bit_r;
  assign out_zero_count   = out_zc_r;
  assign out_out_of_range = out_oor_r;

endmodule

### hdl/wavelet_matrix_builder.sv
// Wavelet matrix builder: loads a text, builds the matrix after the last
// symbol and answers bit queries. Top level; depends on wmb_pkg, wmb_if,
// wmb_ctrl and wmb_dp.
// Load words are accepted back to back. A query word holds off the next word
// until its result goes into the result register. The word with last_symbol
// set starts the build, during which no word is accepted. Every text, bucket
// histogram and border access goes through single-port memories
// with registered reads.
module wavelet_matrix_builder (
  input  logic       clk,
  input  logic       rst_n,
  wmb_in_if.sink     in_ch,
  wmb_out_if.source  out_ch,
  wmb_cfg_if.sink    cfg_ch
);

  wmb_pkg::op_t        op;
  wmb_pkg::dp_status_t status;

  assign cfg_ch.ready = 1'b1;

  wmb_ctrl u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_ch.valid),
    .in_req_type    (in_ch.req_type),
    .in_last_symbol (in_ch.last_symbol),
    .status         (status),
    .in_ready       (in_ch.ready),
    .op             (op)
  );

  wmb_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .status           (status),
    .in_symbol        (in_ch.symbol),
    .in_last_symbol   (in_ch.last_symbol),
    .in_level         (in_ch.level),
    .in_position      (in_ch.position),
    .cfg_we           (cfg_ch.valid),
    .cfg_height       (cfg_ch.height),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_bit_value    (out_ch.bit_value),
    .out_zero_count   (out_ch.zero_count),
    .out_out_of_range (out_ch.out_of_range)
  );

endmodule

### hdl/wmb_checker.sv
// Port-level checks for the wavelet matrix builder, bound to the top level.
// Depends on wmb_pkg.
module wmb_checker (
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      in_req_type,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic                      out_bit_value,
  input logic [wmb_pkg::LEN_W-1:0] out_zero_count,
  input logic                      out_out_of_range
);

  // a result word never appears without a query word before it
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready && in_req_type, 2)
                      || !$past(out_ready))
    else $error("result word without query");

  a_oor_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_out_of_range |-> !out_bit_value && out_zero_count == '0)
    else $error("out of range result carries data");

  a_zc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_zero_count <= wmb_pkg::LEN_W'(wmb_pkg::MAX_LEN))
    else $error("zero count beyond text size");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_zero_count))
    else $error("stalled result word dropped");

endmodule

bind wavelet_matrix_builder wmb_checker u_wmb_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_req_type      (in_ch.req_type),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_bit_value    (out_ch.bit_value),
  .out_zero_count   (out_ch.zero_count),
  .out_out_of_range (out_ch.out_of_range)
);
